// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that stays live through reset
`define DDE_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

// ===== hw/rtl/dde_pkg.sv =====
// ----------------------------------------------------------------------------
// dde_pkg
// Types and constants for the date-digits to epoch-seconds converter.
// ----------------------------------------------------------------------------
package dde_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned CountW = 4;
    localparam int unsigned DigitW = 4;
    localparam int unsigned SecsW  = 32;

    localparam logic [SecsW-1:0] SecsPerMin  = 32'd60;
    localparam logic [SecsW-1:0] SecsPerHour = 32'd3600;
    localparam logic [SecsW-1:0] SecsPerDay  = 32'd86400;
    localparam logic [SecsW-1:0] SecsPerYear = 32'd31536000;

    localparam logic [CountW-1:0] CountCap = 4'd13;
    localparam logic [CountW-1:0] LenShort = 4'd10;
    localparam logic [CountW-1:0] LenLong  = 4'd12;

    localparam logic [6:0] YearPivot   = 7'd70;
    // two-digit years below the pivot sit 30 years past 1970
    localparam logic [6:0] CenturyLift = 7'd30;
    localparam logic [6:0] MonthMax    = 7'd12;
    localparam logic [6:0] MonthFeb    = 7'd2;

    localparam logic [CharW-1:0] AsciiZero = 8'h30;
    localparam logic [CharW-1:0] AsciiNine = 8'h39;

    // Index of the digit pair within the string
    localparam logic [2:0] PAIR_YEAR  = 3'd0;
    localparam logic [2:0] PAIR_MONTH = 3'd1;
    localparam logic [2:0] PAIR_DAY   = 3'd2;
    localparam logic [2:0] PAIR_HOUR  = 3'd3;
    localparam logic [2:0] PAIR_MIN   = 3'd4;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [DigitW-1:0] high;
        logic [SecsW-1:0]  secs;
        logic              leap;
        logic              err;
    } t_fold_state;

    typedef struct packed {
        logic [SecsW-1:0] secs;
        logic             err;
    } t_result;

    // Days before a month of a common year; month zero adds nothing
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/dde_in_stage.sv =====
// ----------------------------------------------------------------------------
// dde_in_stage
// Input register: holds one character beat until the fold logic takes it.
// ----------------------------------------------------------------------------
module dde_in_stage
    import dde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [CharW-1:0] i_s_tdata,   // [7:0] char_code
    input  logic             i_s_tlast,   // last_char
    input  logic             i_take,
    output logic             o_valid,
    output logic [CharW-1:0] o_char,
    output logic             o_last
);

    logic             r_valid;
    logic [CharW-1:0] r_char;
    logic             r_last;

    // accept when empty or when the held beat leaves this cycle
    assign o_s_tready = !r_valid || i_take;

    // track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // load payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
            r_last <= i_s_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// ===== hw/rtl/dde_fold.sv =====
// ----------------------------------------------------------------------------
// dde_fold
// Folds one character into the running second count and forms the result.
// ----------------------------------------------------------------------------
module dde_fold
    import dde_pkg::*;
(
    input  t_fold_state      i_state,
    input  logic [CharW-1:0] i_char,
    output t_fold_state      o_next,
    output t_result          o_result
);

    logic              digit;
    logic [CharW-1:0]  char_off;
    logic [DigitW-1:0] d;
    logic [6:0]        v;
    logic [6:0]        k;
    logic [6:0]        k_leap;
    logic [6:0]        k_next;
    logic [8:0]        mdays;
    logic [SecsW-1:0]  year_secs;
    logic [SecsW-1:0]  add_secs;
    logic              month_bad;

    always_comb begin
        // decode the character
        digit    = (i_char >= AsciiZero) && (i_char <= AsciiNine);
        char_off = i_char - AsciiZero;
        d        = digit ? char_off[DigitW-1:0] : '0;

        // pair value 10*high + digit
        v = {i_state.high, 3'b000} + {2'b00, i_state.high, 1'b0} + {3'b000, d};

        // years since 1970 and the leap days before that year
        k         = (v >= YearPivot) ? (v - YearPivot) : (v + CenturyLift);
        k_next    = k + 7'd1;
        k_leap    = k + 7'd2;
        year_secs = SecsW'(k) * SecsPerYear + SecsW'(k_next[6:2]) * SecsPerDay;

        // whole months of the parsed year
        month_bad = v > MonthMax;
        mdays     = days_before_month(v[3:0])
                  + {8'd0, i_state.leap && (v > MonthFeb)};

        // select what this pair contributes
        unique case (i_state.count[3:1])
            PAIR_YEAR:  add_secs = year_secs;
            PAIR_MONTH: add_secs = month_bad ? '0 : SecsW'(mdays) * SecsPerDay;
            PAIR_DAY:   add_secs = SecsW'(v) * SecsPerDay - SecsPerDay;
            PAIR_HOUR:  add_secs = SecsW'(v) * SecsPerHour;
            PAIR_MIN:   add_secs = SecsW'(v) * SecsPerMin;
            default:    add_secs = SecsW'(v);
        endcase

        // advance state
        o_next = i_state;
        if (i_state.count < LenLong) begin
            if (!digit) begin
                o_next.err = 1'b1;
            end
            if (!i_state.count[0]) begin
                o_next.high = d;
            end else begin
                o_next.secs = i_state.secs + add_secs;
                if (i_state.count[3:1] == PAIR_YEAR) begin
                    o_next.leap = (k_leap[1:0] == 2'b00);
                end
                if ((i_state.count[3:1] == PAIR_MONTH) && month_bad) begin
                    o_next.err = 1'b1;
                end
            end
        end
        if (i_state.count < CountCap) begin
            o_next.count = i_state.count + 4'd1;
        end

        // result as seen if this is the last character
        o_result.err  = o_next.err || ((o_next.count != LenShort) && (o_next.count != LenLong));
        o_result.secs = o_result.err ? '0 : o_next.secs;
    end

endmodule

// ===== hw/rtl/date_digits_to_epoch_seconds_top.sv =====
// Result: o_m_tvalid rises at the edge that moves a last-character beat from the
//   input register into the output register; a full output register delays it.
// Throughput: one character beat per cycle; the fold of a beat into the running
//   count is combinational between the input and state registers. A last beat
//   waits in the input register while an untaken result holds the output register.
// Reset (i_rst_n low, synchronous): clears the input and output registers
//   and the parse state; the first beat after reset starts a new string.
// ----------------------------------------------------------------------------
// date_digits_to_epoch_seconds_top
// Converts a yymmddhhmm[ss] ASCII stream into seconds since 1970.
// ----------------------------------------------------------------------------
module date_digits_to_epoch_seconds_top
    import dde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [CharW-1:0] i_s_tdata,   // [7:0] char_code
    input  logic             i_s_tlast,   // last_char
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [SecsW-1:0] o_m_tdata,   // [31:0] epoch_seconds
    output logic             o_m_tuser    // [0] parse_error
);

    logic             in_valid;
    logic [CharW-1:0] in_char;
    logic             in_last;
    logic             out_free;
    logic             fire;
    t_fold_state      r_state;
    t_fold_state      fold_next;
    t_result          fold_res;
    logic             r_out_valid;
    t_result          r_out;

    // a beat moves on unless it carries a result and the output is full
    assign out_free = !r_out_valid || i_m_tready;
    assign fire     = in_valid && (!in_last || out_free);

    dde_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_take     (fire),
        .o_valid    (in_valid),
        .o_char     (in_char),
        .o_last     (in_last)
    );

    dde_fold u_fold (
        .i_state  (r_state),
        .i_char   (in_char),
        .o_next   (fold_next),
        .o_result (fold_res)
    );

    // update parse state; drop it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (fire) begin
            r_state <= in_last ? '0 : fold_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && in_last) begin
            r_out <= fold_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.secs;
    assign o_m_tuser  = r_out.err;

endmodule

// ===== hw/rtl/dde_checker.sv =====
// ----------------------------------------------------------------------------
// dde_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dde_checker
    import dde_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             i_s_tlast,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [SecsW-1:0] o_m_tdata,
    input logic             o_m_tuser
);

    logic s_last_beat;
    logic m_stall;

    assign s_last_beat = i_s_tvalid && o_s_tready && i_s_tlast;
    assign m_stall     = o_m_tvalid && !i_m_tready;

    // a stalled result beat holds
    `DDE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_stall, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // a failed parse reports zero seconds
    `DDE_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == '0)

    // a fresh result is preceded by an accepted last beat
    `DDE_ASSERT_IMP(a_out_latency, i_clk, i_rst_n, $rose(o_m_tvalid), $past(s_last_beat, 2))

    // reset empties the output
    `DDE_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind date_digits_to_epoch_seconds_top dde_checker u_dde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== tb/dde_epoch_checker.sv =====
// ----------------------------------------------------------------------------
// dde_epoch_checker
// Watches the character and result streams of the date-to-epoch converter.
// Folds every accepted character beat into its own running second count,
// queues the expected result on each last beat and compares each result
// beat, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module dde_epoch_checker
    import dde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [CharW-1:0] i_s_tdata,    // [7:0] char_code
    input  logic             i_s_tlast,    // last_char
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [SecsW-1:0] i_m_tdata,    // [31:0] epoch_seconds
    input  logic             i_m_tuser,    // [0] parse_error
    output int               o_fail_count,
    output int               o_pending
);

    // Days before each month of a common year; month zero adds nothing
    int unsigned cum_days [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    // Predicted parse state
    int unsigned       chars_seen;
    logic [DigitW-1:0] first_digit;
    logic [SecsW-1:0]  partial_secs;
    logic              leap_yr;
    logic              bad_seen;

    // Expected timestamps, oldest first
    t_result           stamps_q [$];
    t_result           want;
    t_result           got;
    logic              is_digit;
    logic [DigitW-1:0] digit_val;

    function automatic int unsigned leaps_upto(input int unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic void clear_fold();
        chars_seen   = 0;
        first_digit  = '0;
        partial_secs = '0;
        leap_yr      = 1'b0;
        bad_seen     = 1'b0;
    endfunction

    // Add one two-digit field to the running second count
    function automatic void fold_pair(input logic [2:0] slot, input logic [6:0] v);
        int unsigned year;
        int unsigned days;
        case (slot)
            PAIR_YEAR: begin
                year = (v < YearPivot) ? 2000 + v : 1900 + v;
                days = 365 * (year - 1970) + leaps_upto(year - 1) - leaps_upto(1969);
                partial_secs += days * SecsPerDay;
                leap_yr = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
            end
            PAIR_MONTH: begin
                if (v > MonthMax) begin
                    bad_seen = 1'b1;
                end else begin
                    days = cum_days[v] + ((leap_yr && v > MonthFeb) ? 1 : 0);
                    partial_secs += days * SecsPerDay;
                end
            end
            // day zero steps back one day and may wrap
            PAIR_DAY:  partial_secs += v * SecsPerDay - SecsPerDay;
            PAIR_HOUR: partial_secs += v * SecsPerHour;
            PAIR_MIN:  partial_secs += v * SecsPerMin;
            default:   partial_secs += v;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_fold();
            stamps_q.delete();
            o_fail_count = 0;
        end else begin
            // Compare a result beat with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got.secs = i_m_tdata;
                got.err  = i_m_tuser;
                if (stamps_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: secs=%0d err=%0b", got.secs, got.err);
                    o_fail_count++;
                end else begin
                    want = stamps_q.pop_front();
                    if (got.secs !== want.secs || got.err !== want.err) begin
                        if (o_fail_count < 10)
                            $display("result mismatch: secs exp=%0d got=%0d, err exp=%0b got=%0b",
                                     want.secs, got.secs, want.err, got.err);
                        o_fail_count++;
                    end
                end
            end

            // Fold a character beat; emit an expectation on the last one
            if (i_s_tvalid && i_s_tready) begin
                is_digit  = (i_s_tdata >= AsciiZero) && (i_s_tdata <= AsciiNine);
                digit_val = is_digit ? DigitW'(i_s_tdata - AsciiZero) : '0;
                if (chars_seen < 12) begin
                    if (!is_digit)
                        bad_seen = 1'b1;
                    if (chars_seen % 2 == 0)
                        first_digit = digit_val;
                    else
                        fold_pair(3'(chars_seen / 2), 7'(first_digit * 10 + digit_val));
                end
                if (chars_seen < CountCap)
                    chars_seen++;
                if (i_s_tlast) begin
                    want.err  = bad_seen || (chars_seen != LenShort && chars_seen != LenLong);
                    want.secs = want.err ? '0 : partial_secs;
                    stamps_q.push_back(want);
                    clear_fold();
                end
            end
        end
        o_pending = stamps_q.size();
    end

endmodule

// ===== tb/tb_date_digits_to_epoch_seconds_top.sv =====
// ----------------------------------------------------------------------------
// tb_date_digits_to_epoch_seconds_top
// Feeds date strings, one character beat at a time, into the converter:
// directed corner strings first, then random well-formed dates mixed with
// broken and noisy strings. Both sides idle at random, and once the result
// side holds off long enough to back the block up. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_date_digits_to_epoch_seconds_top;
    import dde_pkg::*;

    localparam int IdleLimit  = 1000;
    localparam int LongHold   = 80;
    localparam int CharTarget = 850;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             o_s_tready;
    logic [CharW-1:0] s_tdata;     // [7:0] char_code
    logic             s_tlast;     // last_char
    logic             o_m_tvalid;
    logic             m_tready;
    logic [SecsW-1:0] o_m_tdata;   // [31:0] epoch_seconds
    logic             o_m_tuser;   // [0] parse_error

    int               fail_count;
    int               pending;
    int               chars_sent;
    int               idle_cycles;
    int               burst_strings;
    int               rx_run;
    int               rx_stall;
    int               kind;
    bit               hold_req;
    bit               hold_taken;
    logic [CharW-1:0] text_q [$];

    date_digits_to_epoch_seconds_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    dde_epoch_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Append characters of a literal to the pending string
    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Append a two-digit decimal field
    task automatic push_pair(input int v);
        text_q.push_back(AsciiZero + CharW'(v / 10));
        text_q.push_back(AsciiZero + CharW'(v % 10));
    endtask

    // Offer one character beat and hold it until accepted; enter and leave at negedge
    task automatic drive_char(input logic [CharW-1:0] ch, input logic lst, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= lst;
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    // Send the pending string, last beat marked, then clear it
    task automatic send_text(input bit no_gap);
        for (int k = 0; k < text_q.size(); k++)
            drive_char(text_q[k], k == text_q.size() - 1, no_gap);
        text_q.delete();
    endtask

    // Build a random well-formed date, mostly in range, sometimes oversized
    task automatic push_date();
        push_pair($urandom_range(0, 99));
        push_pair(($urandom_range(0, 9) == 0) ? $urandom_range(13, 99) : $urandom_range(0, 12));
        push_pair(($urandom_range(0, 6) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31));
        push_pair(($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23));
        push_pair(($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59));
        if ($urandom_range(0, 1) == 1)
            push_pair($urandom_range(0, 99));
    endtask

    // Result side: per result draw a stall, with runs of no stall and one long hold
    initial begin
        m_tready = 1'b0;
        rx_run   = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (rx_run == 0 && $urandom_range(0, 7) == 0)
                rx_run = 15;
            if (hold_req && !hold_taken) begin
                rx_stall   = LongHold;
                hold_taken = 1'b1;
            end else if (rx_run > 0) begin
                rx_stall = 0;
                rx_run--;
            end else begin
                rx_stall = $urandom_range(0, 6);
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                repeat (rx_stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!o_m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("tb_date_digits_to_epoch_seconds_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        chars_sent    = 0;
        idle_cycles   = 0;
        burst_strings = 0;
        hold_req      = 1'b0;
        hold_taken    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: epoch start, year pivot edges, leap days
        push_str("7001010000");   send_text(1'b0);
        push_str("691231235959"); send_text(1'b0);
        push_str("9912310000");   send_text(1'b0);
        push_str("0002291200");   send_text(1'b0);
        push_str("000301000000"); send_text(1'b1);
        push_str("6802290000");   send_text(1'b0);
        // day zero wraps below the epoch; month zero adds nothing
        push_str("7001000000");   send_text(1'b0);
        push_str("0000000000");   send_text(1'b0);
        // oversized hours, minutes and seconds
        push_str("700101999999"); send_text(1'b0);
        // month above twelve
        push_str("7013010000");   send_text(1'b0);
        push_str("999999999999"); send_text(1'b0);
        // non-digits next to the digit range, NUL and all-ones
        push_str("70010100/:");   send_text(1'b0);
        push_str("70010");
        text_q.push_back(8'h00);
        push_str("000");
        text_q.push_back(8'hFF);
        send_text(1'b0);
        // lengths eleven, thirteen, sixteen and one
        push_str("70010100000");      send_text(1'b0);
        push_str("7001010000000");    send_text(1'b1);
        push_str("7001010000009999"); send_text(1'b0);
        push_str("7");                send_text(1'b0);

        // Random: mostly well-formed dates, some extended, some noise
        while (chars_sent < CharTarget) begin
            if (!hold_req && chars_sent >= 300) begin
                hold_req      = 1'b1;
                burst_strings = 10;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                push_date();
            end else if (kind == 7) begin
                push_date();
                repeat ($urandom_range(1, 4))
                    text_q.push_back(AsciiZero + CharW'($urandom_range(0, 9)));
            end else begin
                repeat ($urandom_range(1, 16)) begin
                    if ($urandom_range(0, 1) == 0)
                        text_q.push_back(AsciiZero + CharW'($urandom_range(0, 9)));
                    else
                        text_q.push_back(CharW'($urandom_range(0, 255)));
                end
            end
            if (burst_strings > 0) begin
                burst_strings--;
                send_text(1'b1);
            end else begin
                send_text($urandom_range(0, 3) == 0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait out every expected result, then the output latency
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_date_digits_to_epoch_seconds_top OK");
        else
            $display("tb_date_digits_to_epoch_seconds_top NOT OK");
        $finish;
    end

endmodule

// ===== date_digits_to_epoch_seconds_top.f =====
+incdir+hw/rtl
hw/rtl/dde_pkg.sv
hw/rtl/dde_in_stage.sv
hw/rtl/dde_fold.sv
hw/rtl/date_digits_to_epoch_seconds_top.sv
hw/rtl/dde_checker.sv
tb/dde_epoch_checker.sv
tb/tb_date_digits_to_epoch_seconds_top.sv
